// ===== hw/rtl/bcd_time_code_modulator_unit_defines.svh =====
// assertion macros shared by the time code modulator rtl
`ifndef BCD_TIME_CODE_MODULATOR_UNIT_DEFINES_SVH
`define BCD_TIME_CODE_MODULATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BCTM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bctm assertion failed");

// next-cycle implication, checked outside reset
`define BCTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bctm assertion failed");

`endif

// ===== hw/rtl/bctm_pkg.sv =====
// shared types and constants of the bcd time code modulator
package bctm_pkg;

    localparam int unsigned SAMPLES_PER_MS = 2000;

    localparam int unsigned SEC_W    = 6;
    localparam int unsigned SAMPLE_W = 21;
    localparam int unsigned LEVEL_W  = 16;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DAY    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR   = CFG_IDX_W'(3);

    localparam logic [SEC_W-1:0] SECONDS_PER_FRAME = SEC_W'(60);

    localparam int unsigned GAP_SAMPLES = 30 * SAMPLES_PER_MS;
    localparam int unsigned END_ZERO    = GAP_SAMPLES + 200 * SAMPLES_PER_MS;
    localparam int unsigned END_ONE     = GAP_SAMPLES + 500 * SAMPLES_PER_MS;
    localparam int unsigned END_MARKER  = GAP_SAMPLES + 800 * SAMPLES_PER_MS;

    localparam int unsigned THR_W = $clog2(END_MARKER + 1);
    localparam int unsigned CMP_W = (THR_W > SAMPLE_W) ? THR_W : SAMPLE_W;

    localparam logic [LEVEL_W-1:0] LEVEL_HIGH = LEVEL_W'(11796);
    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = LEVEL_W'(1966);

    typedef enum logic [1:0] {
        SYM_ZERO   = 2'd0,
        SYM_ONE    = 2'd1,
        SYM_MARKER = 2'd2
    } t_symbol;

    typedef struct packed {
        logic [3:0] mn_lo;
        logic [2:0] mn_hi;
        logic [3:0] hr_lo;
        logic [1:0] hr_hi;
        logic [3:0] dy_lo;
        logic [3:0] dy_mid;
        logic [2:0] dy_hi;
        logic [3:0] yr_lo;
        logic [3:0] yr_hi;
    } t_digits;

endpackage

// ===== hw/rtl/bctm_symbol_dec.sv =====
// symbol decoder: second of the minute and bcd digits to frame symbol
module bctm_symbol_dec (
    input  logic [bctm_pkg::SEC_W-1:0] i_sec,
    input  bctm_pkg::t_digits          i_digits,
    output bctm_pkg::t_symbol          o_symbol
);

    logic [1:0] sel;
    logic       bit_val;

    always_comb begin
        sel     = '0;
        bit_val = 1'b0;
        o_symbol = bctm_pkg::SYM_ZERO;
        unique case (i_sec) inside
            6'd0, 6'd9, 6'd19, 6'd29, 6'd39, 6'd49, 6'd59: begin
                o_symbol = bctm_pkg::SYM_MARKER;
            end
            [6'd5:6'd8]: begin
                sel     = 2'(i_sec - 6'd5);
                bit_val = i_digits.mn_lo[sel];
            end
            [6'd10:6'd12]: begin
                sel     = 2'(i_sec - 6'd10);
                bit_val = i_digits.mn_hi[sel];
            end
            [6'd15:6'd18]: begin
                sel     = 2'(i_sec - 6'd15);
                bit_val = i_digits.hr_lo[sel];
            end
            [6'd20:6'd21]: begin
                sel     = 2'(i_sec - 6'd20);
                bit_val = i_digits.hr_hi[sel[0]];
            end
            [6'd25:6'd28]: begin
                sel     = 2'(i_sec - 6'd25);
                bit_val = i_digits.dy_lo[sel];
            end
            [6'd30:6'd33]: begin
                sel     = 2'(i_sec - 6'd30);
                bit_val = i_digits.dy_mid[sel];
            end
            [6'd35:6'd36]: begin
                sel     = 2'(i_sec - 6'd35);
                bit_val = i_digits.dy_hi[sel[0]];
            end
            [6'd45:6'd48]: begin
                sel     = 2'(i_sec - 6'd45);
                bit_val = i_digits.yr_lo[sel];
            end
            [6'd53:6'd54]: begin
                sel     = 2'(i_sec - 6'd53);
                bit_val = i_digits.yr_hi[sel];
            end
            [6'd56:6'd57]: begin
                sel     = 2'(i_sec - 6'd54);
                bit_val = i_digits.yr_hi[sel];
            end
            default: begin
                bit_val = 1'b0;
            end
        endcase
        if (bit_val) begin
            o_symbol = bctm_pkg::SYM_ONE;
        end
    end

endmodule

// ===== hw/rtl/bcd_time_code_modulator_unit.sv =====
// bcd time code modulator top level: config registers and three-stage envelope pipeline
//
//  channel   direction  handshake                     word
//  s_axis    in         s_axis_tvalid/s_axis_tready   second index, sample index
//  m_axis    out        m_axis_tvalid/m_axis_tready   pulse flag, level; symbol in tuser
//  cfg       in         i_cfg_valid/o_cfg_ready       register index, data
//
//  one word per cycle while the output word is not waiting; an accepted word
//  moves through the stage 1 and stage 2 registers into the output register
//  stage 1: input capture and bcd split, stage 2: symbol decode and
//  threshold compares, stage 3: pulse select into the output register
//  the whole pipe holds while the output word waits; nothing is lost
//  synchronous reset clears valid bits and config registers to zero
//  config writes are always taken

`include "bcd_time_code_modulator_unit_defines.svh"

module bcd_time_code_modulator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,  // second_index, sample_index
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [23:0]                         m_axis_tdata,  // pulse_high, envelope_level
    output logic [1:0]                          m_axis_tuser,  // symbol_kind
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bctm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bctm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    function automatic logic [5:0] div10(input logic [8:0] x);
        logic [16:0] p;
        p = x * 17'd205;
        return p[16:11];
    endfunction

    logic [5:0] r_minute;
    logic [4:0] r_hour;
    logic [8:0] r_day;
    logic [6:0] r_year;

    // config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minute <= '0;
            r_hour   <= '0;
            r_day    <= '0;
            r_year   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bctm_pkg::CFG_MINUTE: r_minute <= i_cfg_data[5:0];
                bctm_pkg::CFG_HOUR:   r_hour   <= i_cfg_data[4:0];
                bctm_pkg::CFG_DAY:    r_day    <= i_cfg_data[8:0];
                bctm_pkg::CFG_YEAR:   r_year   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // bcd split
    logic [5:0] q_min, q_hour, q_day, q_day2, q_year;
    logic [9:0] dy_mid_full;
    bctm_pkg::t_digits n_digits;

    always_comb begin
        q_min  = div10({3'd0, r_minute});
        q_hour = div10({4'd0, r_hour});
        q_day  = div10(r_day);
        q_day2 = div10({3'd0, q_day});
        q_year = div10({2'd0, r_year});
        dy_mid_full = 10'(q_day) - 10'(q_day2) * 10'd10;
        n_digits.mn_lo  = 4'(6'(r_minute) - 6'(q_min * 6'd10));
        n_digits.mn_hi  = q_min[2:0];
        n_digits.hr_lo  = 4'(6'(r_hour) - 6'(q_hour * 6'd10));
        n_digits.hr_hi  = q_hour[1:0];
        n_digits.dy_lo  = 4'(9'(r_day) - 9'(q_day * 9'd10));
        n_digits.dy_mid = dy_mid_full[3:0];
        n_digits.dy_hi  = q_day2[2:0];
        n_digits.yr_lo  = 4'(7'(r_year) - 7'(q_year * 7'd10));
        n_digits.yr_hi  = q_year[3:0];
    end

    // pipeline
    logic ce;
    logic r_v1, r_v2, r_v3;

    logic [bctm_pkg::SEC_W-1:0]    r_sec1;
    logic [bctm_pkg::SAMPLE_W-1:0] r_sample1;
    bctm_pkg::t_digits             r_digits1;

    bctm_pkg::t_symbol r_sym2;
    logic              r_sec_ok2;
    logic              r_ge_gap2;
    logic              r_lt_zero2, r_lt_one2, r_lt_mark2;

    bctm_pkg::t_symbol r_sym3;
    logic              r_high3;

    bctm_pkg::t_symbol           dec_symbol;
    logic [bctm_pkg::CMP_W-1:0]  samp_ext;
    logic                        n_high;

    assign ce            = !r_v3 || m_axis_tready;
    assign s_axis_tready = ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (ce) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    bctm_symbol_dec u_symbol_dec (
        .i_sec    (r_sec1),
        .i_digits (r_digits1),
        .o_symbol (dec_symbol)
    );

    assign samp_ext = bctm_pkg::CMP_W'(r_sample1);

    always_comb begin
        unique case (r_sym2)
            bctm_pkg::SYM_MARKER: n_high = r_ge_gap2 && r_lt_mark2;
            bctm_pkg::SYM_ONE:    n_high = r_ge_gap2 && r_lt_one2;
            default:              n_high = r_ge_gap2 && r_lt_zero2;
        endcase
        n_high = n_high && r_sec_ok2;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sec1     <= s_axis_tdata[5:0];
            r_sample1  <= s_axis_tdata[26:6];
            r_digits1  <= n_digits;

            r_sym2     <= (r_sec1 < bctm_pkg::SECONDS_PER_FRAME) ? dec_symbol
                                                                 : bctm_pkg::SYM_ZERO;
            r_sec_ok2  <= r_sec1 < bctm_pkg::SECONDS_PER_FRAME;
            r_ge_gap2  <= samp_ext >= bctm_pkg::CMP_W'(bctm_pkg::GAP_SAMPLES);
            r_lt_zero2 <= samp_ext <  bctm_pkg::CMP_W'(bctm_pkg::END_ZERO);
            r_lt_one2  <= samp_ext <  bctm_pkg::CMP_W'(bctm_pkg::END_ONE);
            r_lt_mark2 <= samp_ext <  bctm_pkg::CMP_W'(bctm_pkg::END_MARKER);

            r_sym3     <= r_sym2;
            r_high3    <= n_high;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tuser  = r_sym3;
    assign m_axis_tdata  = {7'd0,
                            (r_high3 ? bctm_pkg::LEVEL_HIGH : bctm_pkg::LEVEL_LOW),
                            r_high3};

    // checks
    `BCTM_ASSERT_SAME(a_stall_holds_input, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tready), !s_axis_tready)
    `BCTM_ASSERT_SAME(a_symbol_code, i_clk, i_rst_n,
        m_axis_tvalid, (m_axis_tuser != 2'd3))
    `BCTM_ASSERT_NEXT(a_bad_second_low, i_clk, i_rst_n,
        (ce && r_v2 && !r_sec_ok2), (r_v3 && !r_high3 && r_sym3 == bctm_pkg::SYM_ZERO))

endmodule

// ===== tb/tb_bcd_time_code_modulator_unit.sv =====
// testbench of the bcd time code modulator: directed table and random words against a predictor
`timescale 1ns / 100ps

module tb_bcd_time_code_modulator_unit;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned PHASES      = 13;
    localparam int unsigned PHASE_WORDS = 100;

    localparam logic [15:0] LEVEL_UP   = 16'd11796;
    localparam logic [15:0] LEVEL_DOWN = 16'd1966;

    localparam longint GAP_LEN    = 30 * bctm_pkg::SAMPLES_PER_MS;
    localparam longint ZERO_LEN   = 200 * bctm_pkg::SAMPLES_PER_MS;
    localparam longint ONE_LEN    = 500 * bctm_pkg::SAMPLES_PER_MS;
    localparam longint MARKER_LEN = 800 * bctm_pkg::SAMPLES_PER_MS;

    localparam logic [bctm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LOW = bctm_pkg::CFG_IDX_W'(4);
    localparam logic [bctm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_TOP = '1;

    typedef struct packed {
        bctm_pkg::t_symbol kind;
        logic              high;
        logic [15:0]       level;
    } t_envelope_word;

    typedef struct {
        logic [5:0]        sec;
        logic [20:0]       sample;
        bit                typed;
        bctm_pkg::t_symbol kind;
        logic              high;
    } t_stim_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [31:0]                     s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [23:0]                     m_axis_tdata;
    logic [1:0]                      m_axis_tuser;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [bctm_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bctm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    logic [5:0] clock_minute;
    logic [4:0] clock_hour;
    logic [8:0] clock_day;
    logic [6:0] clock_year;

    t_envelope_word envelope_queue [$];
    t_envelope_word seen_want;
    int unsigned    error_count;
    int unsigned    cycle_count = 0;
    int             send_quiet;
    int             take_quiet;

    t_stim_row directed_rows [23] = '{
        '{6'd0,  21'd0,       1'b1, bctm_pkg::SYM_MARKER, 1'b0},
        '{6'd0,  21'd59999,   1'b1, bctm_pkg::SYM_MARKER, 1'b0},
        '{6'd0,  21'd60000,   1'b1, bctm_pkg::SYM_MARKER, 1'b1},
        '{6'd0,  21'd1659999, 1'b1, bctm_pkg::SYM_MARKER, 1'b1},
        '{6'd0,  21'd1660000, 1'b1, bctm_pkg::SYM_MARKER, 1'b0},
        '{6'd1,  21'd60000,   1'b1, bctm_pkg::SYM_ZERO,   1'b1},
        '{6'd1,  21'd459999,  1'b1, bctm_pkg::SYM_ZERO,   1'b1},
        '{6'd1,  21'd460000,  1'b1, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd60, 21'd60000,   1'b1, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd63, 21'h1FFFFF,  1'b1, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd59, 21'd1999999, 1'b1, bctm_pkg::SYM_MARKER, 1'b0},
        '{6'd5,  21'd1059999, 1'b0, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd8,  21'd460000,  1'b0, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd12, 21'd1000000, 1'b0, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd18, 21'd300000,  1'b0, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd21, 21'd100000,  1'b0, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd28, 21'd1059999, 1'b0, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd33, 21'd1060000, 1'b0, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd36, 21'd500000,  1'b0, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd48, 21'd700000,  1'b0, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd54, 21'd800000,  1'b0, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd57, 21'd900000,  1'b0, bctm_pkg::SYM_ZERO,   1'b0},
        '{6'd42, 21'h155555,  1'b0, bctm_pkg::SYM_ZERO,   1'b0}
    };

    bcd_time_code_modulator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bctm_pkg::t_symbol second_symbol(logic [5:0] sec);
        int  mu, mt, hu, ht, du, dt, dh, yu, yt;
        int  digit;
        int  shift;
        bit  coded;
        mu = clock_minute % 10;
        mt = clock_minute / 10;
        hu = clock_hour % 10;
        ht = clock_hour / 10;
        du = clock_day % 10;
        dt = (clock_day / 10) % 10;
        dh = clock_day / 100;
        yu = clock_year % 10;
        yt = clock_year / 10;
        coded = 1'b1;
        digit = 0;
        shift = 0;
        case (sec)
            0, 9, 19, 29, 39, 49, 59: return bctm_pkg::SYM_MARKER;
            5, 6, 7, 8: begin
                digit = mu;
                shift = sec - 5;
            end
            10, 11, 12: begin
                digit = mt;
                shift = sec - 10;
            end
            15, 16, 17, 18: begin
                digit = hu;
                shift = sec - 15;
            end
            20, 21: begin
                digit = ht;
                shift = sec - 20;
            end
            25, 26, 27, 28: begin
                digit = du;
                shift = sec - 25;
            end
            30, 31, 32, 33: begin
                digit = dt;
                shift = sec - 30;
            end
            35, 36: begin
                digit = dh;
                shift = sec - 35;
            end
            45, 46, 47, 48: begin
                digit = yu;
                shift = sec - 45;
            end
            53, 54: begin
                digit = yt;
                shift = sec - 53;
            end
            56, 57: begin
                digit = yt;
                shift = sec - 54;
            end
            default: coded = 1'b0;
        endcase
        if (coded && ((digit >> shift) & 1) == 1)
            return bctm_pkg::SYM_ONE;
        return bctm_pkg::SYM_ZERO;
    endfunction

    function automatic t_envelope_word predict_envelope(logic [5:0] sec, logic [20:0] sample);
        t_envelope_word w;
        longint         span;
        longint         pos;
        w.kind = bctm_pkg::SYM_ZERO;
        w.high = 1'b0;
        pos = longint'(sample);
        if (sec < 6'd60) begin
            w.kind = second_symbol(sec);
            case (w.kind)
                bctm_pkg::SYM_MARKER: span = MARKER_LEN;
                bctm_pkg::SYM_ONE:    span = ONE_LEN;
                default:              span = ZERO_LEN;
            endcase
            if (pos >= GAP_LEN && pos - GAP_LEN < span)
                w.high = 1'b1;
        end
        w.level = w.high ? LEVEL_UP : LEVEL_DOWN;
        return w;
    endfunction

    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("tb: mismatch in %s: got %0d, want %0d", what, got, want);
        error_count++;
    endtask

    task automatic write_register(logic [bctm_pkg::CFG_IDX_W-1:0] idx,
                                  logic [bctm_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            bctm_pkg::CFG_MINUTE: clock_minute = data[5:0];
            bctm_pkg::CFG_HOUR:   clock_hour   = data[4:0];
            bctm_pkg::CFG_DAY:    clock_day    = data[8:0];
            bctm_pkg::CFG_YEAR:   clock_year   = data[6:0];
            default: ;
        endcase
    endtask

    task automatic drain_envelopes();
        while (envelope_queue.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_sample(logic [5:0] sec, logic [20:0] sample, t_envelope_word want);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, sample, sec};
        do @(posedge i_clk); while (!s_axis_tready);
        envelope_queue.push_back(want);
    endtask

    task automatic run_table(bit use_typed);
        t_envelope_word want;
        foreach (directed_rows[r]) begin
            if (use_typed && directed_rows[r].typed) begin
                want.kind  = directed_rows[r].kind;
                want.high  = directed_rows[r].high;
                want.level = directed_rows[r].high ? LEVEL_UP : LEVEL_DOWN;
            end else begin
                want = predict_envelope(directed_rows[r].sec, directed_rows[r].sample);
            end
            send_sample(directed_rows[r].sec, directed_rows[r].sample, want);
        end
    endtask

    task automatic load_time(int style);
        case (style)
            0: begin
                write_register(bctm_pkg::CFG_MINUTE,
                               bctm_pkg::CFG_DATA_W'($urandom_range(0, 59)));
                write_register(bctm_pkg::CFG_HOUR,
                               bctm_pkg::CFG_DATA_W'($urandom_range(0, 23)));
                write_register(bctm_pkg::CFG_DAY,
                               bctm_pkg::CFG_DATA_W'($urandom_range(0, 366)));
                write_register(bctm_pkg::CFG_YEAR,
                               bctm_pkg::CFG_DATA_W'($urandom_range(0, 99)));
            end
            1: begin
                write_register(bctm_pkg::CFG_YEAR,   bctm_pkg::CFG_DATA_W'($urandom));
                write_register(bctm_pkg::CFG_DAY,    bctm_pkg::CFG_DATA_W'($urandom));
                write_register(bctm_pkg::CFG_HOUR,   bctm_pkg::CFG_DATA_W'($urandom));
                write_register(bctm_pkg::CFG_MINUTE, bctm_pkg::CFG_DATA_W'($urandom));
            end
            2: begin
                write_register(bctm_pkg::CFG_MINUTE, '0);
                write_register(bctm_pkg::CFG_HOUR,   '0);
                write_register(bctm_pkg::CFG_DAY,    '0);
                write_register(bctm_pkg::CFG_YEAR,   '0);
            end
            default: begin
                write_register(bctm_pkg::CFG_MINUTE, bctm_pkg::CFG_DATA_W'(59));
                write_register(bctm_pkg::CFG_HOUR,   bctm_pkg::CFG_DATA_W'(23));
                write_register(bctm_pkg::CFG_DAY,    bctm_pkg::CFG_DATA_W'(366));
                write_register(bctm_pkg::CFG_YEAR,   bctm_pkg::CFG_DATA_W'(99));
            end
        endcase
        if ($urandom_range(0, 1) == 1)
            write_register(CFG_UNUSED_LOW, bctm_pkg::CFG_DATA_W'($urandom));
        else
            write_register(CFG_UNUSED_TOP, bctm_pkg::CFG_DATA_W'($urandom));
    endtask

    task automatic send_random_sample();
        logic [5:0]  sec;
        logic [20:0] sample;
        longint      pos;
        if ($urandom_range(0, 7) == 0)
            sec = 6'($urandom_range(60, 63));
        else
            sec = 6'($urandom_range(0, 59));
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 6))
                0: pos = 0;
                1: pos = GAP_LEN;
                2: pos = GAP_LEN + ZERO_LEN;
                3: pos = GAP_LEN + ONE_LEN;
                4: pos = GAP_LEN + MARKER_LEN;
                5: pos = 1000 * bctm_pkg::SAMPLES_PER_MS;
                default: pos = 21'h1FFFFF;
            endcase
            pos = pos + $urandom_range(0, 8) - 4;
            if (pos < 0)
                pos = 0;
            if (pos > 21'h1FFFFF)
                pos = 21'h1FFFFF;
            sample = 21'(pos);
        end else begin
            sample = 21'($urandom_range(0, 21'h1FFFFF));
        end
        send_sample(sec, sample, predict_envelope(sec, sample));
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // output word check
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (envelope_queue.size() == 0) begin
                report_mismatch("unexpected word", int'(m_axis_tdata), -1);
            end else begin
                seen_want = envelope_queue.pop_front();
                if (m_axis_tuser !== seen_want.kind)
                    report_mismatch("symbol_kind", int'(m_axis_tuser), int'(seen_want.kind));
                if (m_axis_tdata[0] !== seen_want.high)
                    report_mismatch("pulse_high", int'(m_axis_tdata[0]), int'(seen_want.high));
                if (m_axis_tdata[16:1] !== seen_want.level)
                    report_mismatch("envelope_level", int'(m_axis_tdata[16:1]),
                                    int'(seen_want.level));
            end
        end
    end

    // output side stalls
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        take_quiet = 0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = draw_wait(take_quiet);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        error_count   = 0;
        send_quiet    = 0;
        clock_minute  = '0;
        clock_hour    = '0;
        clock_day     = '0;
        clock_year    = '0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_table(1'b1);
        s_axis_tvalid <= 1'b0;
        drain_envelopes();
        load_time(3);
        run_table(1'b0);

        for (int p = 0; p < PHASES; p++) begin
            s_axis_tvalid <= 1'b0;
            drain_envelopes();
            load_time(p % 4);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_random_sample();
        end
        s_axis_tvalid <= 1'b0;

        drain_envelopes();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bctm_pkg.sv
hw/rtl/bctm_symbol_dec.sv
hw/rtl/bcd_time_code_modulator_unit.sv
tb/tb_bcd_time_code_modulator_unit.sv
